FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL top level, rgb_pixel_blend_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

FILE: hdl/rpb_pkg.sv
// Types and constants of the RGB pixel blend unit.
package rpb_pkg;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_BLUE = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED = 2;

  typedef enum logic [2:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SUBTRACT = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_ADD      = 3'd4,
    MODE_SCALE    = 3'd5
  } blend_mode_t;

  typedef enum logic [2:0] {
    CFG_BLEND_MODE   = 3'd0,
    CFG_OFFSET_RED   = 3'd1,
    CFG_OFFSET_GREEN = 3'd2,
    CFG_OFFSET_BLUE  = 3'd3,
    CFG_GAIN_RED     = 3'd4,
    CFG_GAIN_GREEN   = 3'd5,
    CFG_GAIN_BLUE    = 3'd6
  } cfg_index_t;

  // How a channel's product turns into its result.
  typedef enum logic [1:0] {
    KIND_DIV  = 2'd0,  // round(v / 255)
    KIND_INV  = 2'd1,  // 255 - round(v / 255)
    KIND_SAT  = 2'd2,  // product clamped at 255
    KIND_PASS = 2'd3   // value already final
  } kind_t;

  localparam logic [7:0] GAIN_RESET = 8'd1;
  localparam logic [16:0] ROUND_BIAS = 17'd127;
  localparam logic [17:0] DIVISOR = 18'd255;
  localparam logic [17:0] REM_LIMIT = 18'd510;

  typedef struct packed {
    logic [15:0] prod;
    logic        dbl;
    kind_t       kind;
    logic [7:0]  direct;
  } chan_s1_t;

  typedef struct packed {
    logic [16:0] v;
    kind_t       kind;
    logic [7:0]  direct;
  } chan_s2_t;

  typedef struct packed {
    logic [16:0] v;
    logic [8:0]  q0;
    kind_t       kind;
    logic [7:0]  direct;
  } chan_s3_t;

endpackage

FILE: hdl/rgb_pixel_blend_unit.sv
// Top level: four-stage pipelined per-channel pixel blender.
// A request passes registers s1_r, s2_r, s3_r and res_r before its result is valid.
// Throughput: one pixel per cycle while out_ready is high; stage 1 multiplier, stages 2-4 divide by 255.
// A stalled output holds its stage; earlier stages keep filling until full.
// Reset (rst_n low, synchronous) empties the pipeline and loads mode 0,
// offsets 0 and gains 1.
`include "assert_macros.svh"

module rgb_pixel_blend_unit import rpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_top_blue,
  input  logic [7:0] in_top_green,
  input  logic [7:0] in_top_red,
  input  logic [7:0] in_bottom_blue,
  input  logic [7:0] in_bottom_green,
  input  logic [7:0] in_bottom_red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red
);

  logic [2:0] mode_r;
  logic [NUM_CH-1:0][7:0] offset_r;
  logic [NUM_CH-1:0][7:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MULTIPLY;
      offset_r <= '0;
      gain_r <= {NUM_CH{GAIN_RESET}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLEND_MODE:   mode_r <= cfg_data[2:0];
        CFG_OFFSET_RED:   offset_r[CH_RED] <= cfg_data;
        CFG_OFFSET_GREEN: offset_r[CH_GREEN] <= cfg_data;
        CFG_OFFSET_BLUE:  offset_r[CH_BLUE] <= cfg_data;
        CFG_GAIN_RED:     gain_r[CH_RED] <= cfg_data;
        CFG_GAIN_GREEN:   gain_r[CH_GREEN] <= cfg_data;
        CFG_GAIN_BLUE:    gain_r[CH_BLUE] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic adv1, adv2, adv3, adv4;
  logic pipe_full;

  assign adv4 = !s4_v_r || out_ready;
  assign adv3 = !s3_v_r || adv4;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_ready = adv1;
  assign out_valid = s4_v_r;
  assign pipe_full = s1_v_r && s2_v_r && s3_v_r && s4_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
      if (adv4) s4_v_r <= s3_v_r;
    end
  end

  // Stage 1: operand select and multiply
  logic [NUM_CH-1:0][7:0] top_a, bot_b;
  chan_s1_t [NUM_CH-1:0] s1_nxt, s1_r;

  assign top_a[CH_BLUE] = in_top_blue;
  assign top_a[CH_GREEN] = in_top_green;
  assign top_a[CH_RED] = in_top_red;
  assign bot_b[CH_BLUE] = in_bottom_blue;
  assign bot_b[CH_GREEN] = in_bottom_green;
  assign bot_b[CH_RED] = in_bottom_red;

  always_comb begin
    logic [7:0] a, b, x, y;
    logic [8:0] sum;
    for (int c = 0; c < NUM_CH; c++) begin
      a = top_a[c];
      b = bot_b[c];
      sum = {1'b0, a} + {1'b0, offset_r[c]};
      x = a;
      y = b;
      s1_nxt[c].dbl = 1'b0;
      s1_nxt[c].kind = KIND_PASS;
      s1_nxt[c].direct = a;
      unique case (mode_r)
        MODE_MULTIPLY: s1_nxt[c].kind = KIND_DIV;
        MODE_SUBTRACT: s1_nxt[c].direct = (a > b) ? a - b : 8'd0;
        MODE_SCREEN: begin
          x = ~a;
          y = ~b;
          s1_nxt[c].kind = KIND_INV;
        end
        MODE_OVERLAY: begin
          s1_nxt[c].dbl = 1'b1;
          if (b[7]) begin
            x = ~a;
            y = ~b;
            s1_nxt[c].kind = KIND_INV;
          end else begin
            s1_nxt[c].kind = KIND_DIV;
          end
        end
        MODE_ADD: s1_nxt[c].direct = sum[8] ? 8'hff : sum[7:0];
        MODE_SCALE: begin
          y = gain_r[c];
          s1_nxt[c].kind = KIND_SAT;
        end
        default: ;
      endcase
      s1_nxt[c].prod = {8'd0, x} * {8'd0, y};
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1_r <= s1_nxt;
  end

  // Stage 2: overlay doubling, rounding bias, scale saturation
  chan_s2_t [NUM_CH-1:0] s2_nxt, s2_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s2_nxt[c].v = ({1'b0, s1_r[c].prod} << s1_r[c].dbl) + ROUND_BIAS;
      s2_nxt[c].kind = s1_r[c].kind;
      s2_nxt[c].direct = s1_r[c].direct;
      if (s1_r[c].kind == KIND_SAT) begin
        s2_nxt[c].kind = KIND_PASS;
        s2_nxt[c].direct = (s1_r[c].prod[15:8] != 8'd0) ? 8'hff : s1_r[c].prod[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) s2_r <= s2_nxt;
  end

  // Stage 3: quotient estimate v*257/65536, low by at most one
  chan_s3_t [NUM_CH-1:0] s3_nxt, s3_r;

  always_comb begin
    logic [25:0] est;
    for (int c = 0; c < NUM_CH; c++) begin
      est = {9'd0, s2_r[c].v} + {1'b0, s2_r[c].v, 8'd0};
      s3_nxt[c].v = s2_r[c].v;
      s3_nxt[c].q0 = est[24:16];
      s3_nxt[c].kind = s2_r[c].kind;
      s3_nxt[c].direct = s2_r[c].direct;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) s3_r <= s3_nxt;
  end

  // Stage 4: remainder correction and final select
  logic [NUM_CH-1:0][17:0] rem;
  logic [NUM_CH-1:0] rem_hi;
  logic [NUM_CH-1:0][7:0] res_nxt, res_r;

  always_comb begin
    logic [8:0] q;
    for (int c = 0; c < NUM_CH; c++) begin
      rem[c] = {1'b0, s3_r[c].v} - {1'b0, s3_r[c].q0, 8'd0} + {9'd0, s3_r[c].q0};
      rem_hi[c] = (rem[c] >= REM_LIMIT);
      q = s3_r[c].q0 + {8'd0, (rem[c] >= DIVISOR)};
      unique case (s3_r[c].kind)
        KIND_DIV: res_nxt[c] = q[7:0];
        KIND_INV: res_nxt[c] = ~q[7:0];
        default:  res_nxt[c] = s3_r[c].direct;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) res_r <= res_nxt;
  end

  assign out_blue = res_r[CH_BLUE];
  assign out_green = res_r[CH_GREEN];
  assign out_red = res_r[CH_RED];

  `ASSERT_CLK(a_s1_hold, s1_v_r && !adv2 |=> s1_v_r && $stable(s1_r), "stalled stage 1 changed")
  `ASSERT_NEVER(a_rem_range, s3_v_r && (|rem_hi), "quotient estimate off by more than one")
  `ASSERT_NEVER(a_full_stall, pipe_full && !out_ready && in_ready, "full pipeline took a request")

endmodule
